// ===== design/arsl_pkg.sv =====
// Shared types and constants for the address range symbol lookup block.
// No dependencies; every other file in this folder imports it.
package arsl_pkg;

  localparam int unsigned SYMBOL_ENTRIES_DEF  = 1024;
  localparam int unsigned SEGMENT_ENTRIES_DEF = 8;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [31:0] NAME_NONE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_LOAD_SYM = 2'd0,
    FUNC_LOAD_SEG = 2'd1,
    FUNC_LOOKUP   = 2'd2
  } arsl_func_e;

  typedef enum logic [1:0] {
    REG_SYMBOL_COUNT    = 2'd0,
    REG_SEGMENT_COUNT   = 2'd1,
    REG_RELOCATE_ENABLE = 2'd2
  } arsl_reg_e;

  // One segment table entry
  typedef struct packed {
    logic [63:0] start;
    logic [63:0] len;
  } arsl_range_t;

  // One symbol table entry; length is kept to 32 bits
  typedef struct packed {
    logic [63:0] start;
    logic [31:0] len;
    logic [31:0] name;
  } arsl_sym_entry_t;

  typedef struct packed {
    logic        done;
    logic        hit;
    logic [63:0] offset;
  } arsl_seg_rsp_t;

  typedef struct packed {
    logic        done;
    logic        hit;
    logic [31:0] name;
  } arsl_sym_rsp_t;

endpackage

// ===== design/arsl_seg_table.sv =====
// Segment table: synchronous memory of base/length pairs plus a linear scan
// that finds the first segment holding the key. Depends on arsl_pkg.
module arsl_seg_table #(
  parameter int unsigned DEPTH = arsl_pkg::SEGMENT_ENTRIES_DEF,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [AddrW-1:0]       wr_addr_i,
  input  arsl_pkg::arsl_range_t  wr_entry_i,
  input  logic                   go_i,
  input  logic [63:0]            key_i,
  input  logic [CntW-1:0]        count_i,
  output arsl_pkg::arsl_seg_rsp_t rsp_o
);
  import arsl_pkg::*;

  arsl_range_t     seg_mem [DEPTH];
  arsl_range_t     rd_data_q;
  logic            active_q;
  logic [CntW-1:0] addr_q;
  logic            rd_vld_q;
  logic            diff_vld_q;
  logic [64:0]     diff_q;
  logic [63:0]     len_q;
  logic            hit_now;
  logic            scan_done;
  logic            rd_en;

  // diff_q[64] is the borrow: key below base
  assign hit_now   = diff_vld_q && !diff_q[64] && (diff_q[63:0] < len_q);
  assign scan_done = active_q &&
                     (hit_now || ((addr_q >= count_i) && !rd_vld_q && !diff_vld_q));
  assign rd_en     = active_q && !scan_done && (addr_q < count_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      seg_mem[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en) begin
      rd_data_q <= seg_mem[addr_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      diff_q <= {1'b0, key_i} - {1'b0, rd_data_q.start};
      len_q  <= rd_data_q.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      diff_vld_q <= 1'b0;
    end else if (go_i) begin
      active_q   <= 1'b1;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      diff_vld_q <= 1'b0;
    end else begin
      if (scan_done) begin
        active_q <= 1'b0;
      end
      if (rd_en) begin
        addr_q <= addr_q + CntW'(1);
      end
      rd_vld_q   <= rd_en;
      diff_vld_q <= rd_vld_q && active_q && !scan_done;
    end
  end

  assign rsp_o.done   = scan_done;
  assign rsp_o.hit    = hit_now;
  assign rsp_o.offset = diff_q[63:0];

endmodule

// ===== design/arsl_sym_table.sv =====
// Symbol table: synchronous memory of start/length/name triples plus a linear
// scan that finds the first symbol holding the key. Depends on arsl_pkg.
module arsl_sym_table #(
  parameter int unsigned DEPTH = arsl_pkg::SYMBOL_ENTRIES_DEF,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [AddrW-1:0]         wr_addr_i,
  input  arsl_pkg::arsl_sym_entry_t wr_entry_i,
  input  logic                     go_i,
  input  logic [63:0]              key_i,
  input  logic [CntW-1:0]          count_i,
  output arsl_pkg::arsl_sym_rsp_t  rsp_o
);
  import arsl_pkg::*;

  arsl_sym_entry_t sym_mem [DEPTH];
  arsl_sym_entry_t rd_data_q;
  logic            active_q;
  logic [CntW-1:0] addr_q;
  logic            rd_vld_q;
  logic            diff_vld_q;
  logic [64:0]     diff_q;
  logic [31:0]     len_q;
  logic [31:0]     name_q;
  logic            hit_now;
  logic            scan_done;
  logic            rd_en;

  // length is 32 bits, so the upper half of the difference must be zero
  assign hit_now   = diff_vld_q && !diff_q[64] && (diff_q[63:32] == 32'd0) &&
                     (diff_q[31:0] < len_q);
  assign scan_done = active_q &&
                     (hit_now || ((addr_q >= count_i) && !rd_vld_q && !diff_vld_q));
  assign rd_en     = active_q && !scan_done && (addr_q < count_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      sym_mem[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en) begin
      rd_data_q <= sym_mem[addr_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      diff_q <= {1'b0, key_i} - {1'b0, rd_data_q.start};
      len_q  <= rd_data_q.len;
      name_q <= rd_data_q.name;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      diff_vld_q <= 1'b0;
    end else if (go_i) begin
      active_q   <= 1'b1;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      diff_vld_q <= 1'b0;
    end else begin
      if (scan_done) begin
        active_q <= 1'b0;
      end
      if (rd_en) begin
        addr_q <= addr_q + CntW'(1);
      end
      rd_vld_q   <= rd_en;
      diff_vld_q <= rd_vld_q && active_q && !scan_done;
    end
  end

  assign rsp_o.done = scan_done;
  assign rsp_o.hit  = hit_now;
  assign rsp_o.name = name_q;

endmodule

// ===== design/address_range_symbol_lookup.sv =====
// Address range symbol lookup: top level with command port, APB registers
// and lookup sequencer. Depends on arsl_pkg, arsl_seg_table, arsl_sym_table.
//
// Usage:
//   A transaction is taken on a rising edge with start_i high and busy_o low.
//   func_i selects a symbol load, a segment load or a lookup. Loads write one
//   table entry at the accept edge and answer on the next cycle (done_o high
//   for one cycle, found_o 0, name_offset_o all ones, module_offset_o 0).
//   A lookup raises busy_o. With relocation on, the segment table is scanned
//   first, one entry per cycle, and the counter is made segment relative;
//   then the symbol table is scanned the same way until the first hit.
//   Each scan runs as a start pulse, then memory read, subtract stage and
//   compare for each entry, and stops early on a hit. Each table has a single
//   read port, so a scan reads its entries one after another. busy_o drops
//   as the result appears, and the next transaction can then be taken. Only
//   one lookup is in flight.
//   done_o pulses for exactly one cycle per transaction; there is no
//   backpressure on results, the receiver must take them as they come.
//   Registers (APB, 32-bit): 0x0 symbol_count, 0x4 segment_count,
//   0x8 relocate_enable; write only while idle.
//   Reset clears the registers and the sequencer; table contents are
//   undefined until loaded.
module address_range_symbol_lookup #(
  parameter int unsigned SYMBOL_ENTRIES  = arsl_pkg::SYMBOL_ENTRIES_DEF,
  parameter int unsigned SEGMENT_ENTRIES = arsl_pkg::SEGMENT_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        func_i,
  input  logic [9:0]                        entry_index_i,
  input  logic [63:0]                       entry_start_i,
  input  logic [63:0]                       entry_length_i,
  input  logic [31:0]                       entry_name_offset_i,
  input  logic [63:0]                       program_counter_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic [31:0]                       name_offset_o,
  output logic [63:0]                       module_offset_o,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [arsl_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  logic [arsl_pkg::APB_DATA_W-1:0]   pwdata_i,
  output logic [arsl_pkg::APB_DATA_W-1:0]   prdata_o,
  output logic                              pready_o
);
  import arsl_pkg::*;

  localparam int unsigned SymAw = (SYMBOL_ENTRIES > 1) ? $clog2(SYMBOL_ENTRIES) : 1;
  localparam int unsigned SymCw = $clog2(SYMBOL_ENTRIES + 1);
  localparam int unsigned SegAw = (SEGMENT_ENTRIES > 1) ? $clog2(SEGMENT_ENTRIES) : 1;
  localparam int unsigned SegCw = $clog2(SEGMENT_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEG,
    ST_SYM
  } state_e;

  state_e          state_q;
  logic [10:0]     sym_count_q;
  logic [3:0]      seg_count_q;
  logic            reloc_q;
  logic            done_q;
  logic            found_q;
  logic [31:0]     name_q;
  logic [63:0]     mod_off_q;
  logic [63:0]     offset_q;
  logic            pc_zero_q;
  logic            seg_go_q;
  logic            sym_go_q;

  logic            accept;
  logic            apb_wr;
  logic            sym_wr_en;
  logic            seg_wr_en;
  logic [SymCw-1:0] sym_sat;
  logic [SymCw-1:0] sym_cnt;
  logic [SegCw-1:0] seg_cnt;
  arsl_sym_entry_t sym_entry;
  arsl_range_t     seg_entry;
  arsl_seg_rsp_t   seg_rsp;
  arsl_sym_rsp_t   sym_rsp;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign pready_o = 1'b1;
  assign apb_wr   = psel_i && penable_i && pwrite_i;

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_count_q <= '0;
      seg_count_q <= '0;
      reloc_q     <= 1'b0;
    end else if (apb_wr) begin
      case (paddr_i[3:2])
        REG_SYMBOL_COUNT:    sym_count_q <= pwdata_i[10:0];
        REG_SEGMENT_COUNT:   seg_count_q <= pwdata_i[3:0];
        REG_RELOCATE_ENABLE: reloc_q     <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[3:2])
      REG_SYMBOL_COUNT:    prdata_o = APB_DATA_W'(sym_count_q);
      REG_SEGMENT_COUNT:   prdata_o = APB_DATA_W'(seg_count_q);
      REG_RELOCATE_ENABLE: prdata_o = APB_DATA_W'(reloc_q);
      default:             prdata_o = '0;
    endcase
  end

  // Table writes; slots beyond the table depth are dropped
  assign sym_wr_en = accept && (func_i == FUNC_LOAD_SYM) &&
                     (32'(entry_index_i) < SYMBOL_ENTRIES);
  assign seg_wr_en = accept && (func_i == FUNC_LOAD_SEG) &&
                     (32'(entry_index_i) < SEGMENT_ENTRIES);

  assign sym_entry.start = entry_start_i;
  assign sym_entry.len   = entry_length_i[31:0];
  assign sym_entry.name  = entry_name_offset_i;
  assign seg_entry.start = entry_start_i;
  assign seg_entry.len   = entry_length_i;

  // Counts saturate to table depth; a zero program counter searches no symbols
  assign sym_sat = (32'(sym_count_q) > SYMBOL_ENTRIES) ? SymCw'(SYMBOL_ENTRIES)
                                                       : SymCw'(sym_count_q);
  assign sym_cnt = pc_zero_q ? '0 : sym_sat;
  assign seg_cnt = (32'(seg_count_q) > SEGMENT_ENTRIES) ? SegCw'(SEGMENT_ENTRIES)
                                                        : SegCw'(seg_count_q);

  arsl_seg_table #(
    .DEPTH (SEGMENT_ENTRIES)
  ) u_seg_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (seg_wr_en),
    .wr_addr_i  (SegAw'(entry_index_i)),
    .wr_entry_i (seg_entry),
    .go_i       (seg_go_q),
    .key_i      (offset_q),
    .count_i    (seg_cnt),
    .rsp_o      (seg_rsp)
  );

  arsl_sym_table #(
    .DEPTH (SYMBOL_ENTRIES)
  ) u_sym_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (sym_wr_en),
    .wr_addr_i  (SymAw'(entry_index_i)),
    .wr_entry_i (sym_entry),
    .go_i       (sym_go_q),
    .key_i      (offset_q),
    .count_i    (sym_cnt),
    .rsp_o      (sym_rsp)
  );

  // Sequencer; busy_o keeps loads out while a scan reads the tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      found_q   <= 1'b0;
      name_q    <= NAME_NONE;
      mod_off_q <= '0;
      offset_q  <= '0;
      pc_zero_q <= 1'b0;
      seg_go_q  <= 1'b0;
      sym_go_q  <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      seg_go_q <= 1'b0;
      sym_go_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (func_i == FUNC_LOOKUP) begin
              offset_q  <= program_counter_i;
              pc_zero_q <= (program_counter_i == 64'd0);
              if (reloc_q) begin
                seg_go_q <= 1'b1;
                state_q  <= ST_SEG;
              end else begin
                sym_go_q <= 1'b1;
                state_q  <= ST_SYM;
              end
            end else begin
              done_q    <= 1'b1;
              found_q   <= 1'b0;
              name_q    <= NAME_NONE;
              mod_off_q <= '0;
            end
          end
        end
        ST_SEG: begin
          if (seg_rsp.done) begin
            offset_q <= seg_rsp.hit ? seg_rsp.offset : 64'd0;
            sym_go_q <= 1'b1;
            state_q  <= ST_SYM;
          end
        end
        ST_SYM: begin
          if (sym_rsp.done) begin
            done_q    <= 1'b1;
            found_q   <= sym_rsp.hit;
            name_q    <= sym_rsp.hit ? sym_rsp.name : NAME_NONE;
            mod_off_q <= offset_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o          = done_q;
  assign found_o         = found_q;
  assign name_offset_o   = name_q;
  assign module_offset_o = mod_off_q;

endmodule

// ===== design/arsl_checker.sv =====
// Port-level checks for address_range_symbol_lookup, bound to the top level.
// Depends on arsl_pkg.
module arsl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic [1:0]                      func_i,
  input logic                            done_o,
  input logic                            found_o,
  input logic [31:0]                     name_offset_o,
  input logic [63:0]                     module_offset_o,
  input logic                            pready_o
);
  import arsl_pkg::*;

  // Not found always reports the empty name
  a_notfound_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_o |-> name_offset_o == NAME_NONE)
    else $error("not-found result without all-ones name offset");

  // Anything other than a lookup answers on the next cycle with an empty result
  a_load_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && func_i != FUNC_LOOKUP |=>
      done_o && !found_o && module_offset_o == 64'd0 && !busy_o)
    else $error("load transaction did not answer on next cycle");

  // A lookup holds the block busy
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && func_i == FUNC_LOOKUP |=> busy_o && !done_o)
    else $error("lookup accepted without going busy");

  // Leaving busy coincides with the lookup result
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_o)
    else $error("pready low");

endmodule

bind address_range_symbol_lookup arsl_checker u_arsl_checker (.*);

// ===== tb/tb_address_range_symbol_lookup.sv =====
// Self-checking testbench for address_range_symbol_lookup: command port, APB registers.
// Depends on arsl_pkg and the block itself. A clocked driver and monitor sit around an
// in-bench model of the segment and symbol tables that predicts every result.
`timescale 1ns / 1ps

module tb_address_range_symbol_lookup;
  import arsl_pkg::*;

  localparam int SYM_DEPTH    = SYMBOL_ENTRIES_DEF;
  localparam int SEG_DEPTH    = SEGMENT_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 550;
  localparam int TAIL_CYCLES  = 50;
  // ~1700 transactions, each at most a full scan plus the longest gap, x4
  localparam int CYCLE_LIMIT  = 8_000_000;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  func;
    logic [9:0]  idx;
    logic [63:0] start;
    logic [63:0] len;
    logic [31:0] name;
    logic [63:0] pc;
    bit          drain_first;  // hold this one back until all answers are in
  } lookup_cmd_t;

  typedef struct {
    logic        found;
    logic [31:0] name;
    logic [63:0] offset;
  } lookup_ans_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  func_i = '0;
  logic [9:0]  entry_index_i = '0;
  logic [63:0] entry_start_i = '0;
  logic [63:0] entry_length_i = '0;
  logic [31:0] entry_name_offset_i = '0;
  logic [63:0] program_counter_i = '0;
  logic        psel_i = 1'b0;
  logic        penable_i = 1'b0;
  logic        pwrite_i = 1'b0;
  logic [APB_ADDR_W-1:0] paddr_i = '0;
  logic [APB_DATA_W-1:0] pwdata_i = '0;
  logic        busy_o;
  logic        done_o;
  logic        found_o;
  logic [31:0] name_offset_o;
  logic [63:0] module_offset_o;
  logic [APB_DATA_W-1:0] prdata_o;
  logic        pready_o;

  address_range_symbol_lookup dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .entry_index_i, .entry_start_i,
    .entry_length_i, .entry_name_offset_i, .program_counter_i, .done_o, .found_o,
    .name_offset_o, .module_offset_o, .psel_i, .penable_i, .pwrite_i, .paddr_i,
    .pwdata_i, .prdata_o, .pready_o
  );

  always #5 clk_i = ~clk_i;

  // Table model, updated at the accept edge
  logic [63:0] tbl_sym_start [SYM_DEPTH];
  logic [31:0] tbl_sym_len   [SYM_DEPTH];
  logic [31:0] tbl_sym_name  [SYM_DEPTH];
  logic [63:0] tbl_seg_base  [SEG_DEPTH];
  logic [63:0] tbl_seg_len   [SEG_DEPTH];
  logic [10:0] cfg_sym_count = '0;
  logic [3:0]  cfg_seg_count = '0;
  logic        cfg_reloc = 1'b0;

  // What the queued loads will leave in the tables; steers the stimulus
  logic [63:0] plan_sym_start [SYM_DEPTH];
  logic [31:0] plan_sym_len   [SYM_DEPTH];
  logic [63:0] plan_seg_base  [SEG_DEPTH];
  bit          seg_planned    [SEG_DEPTH];

  lookup_cmd_t cmd_q[$];
  lookup_ans_t answer_q[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  bit          cmd_taken = 1'b0;
  bit          burst_mode = 1'b0;
  bit          drain_next = 1'b0;
  int          mixed_items = 0;
  logic [63:0] phase_base = '0;

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int eff_sym();
    return (cfg_sym_count > SYM_DEPTH) ? SYM_DEPTH : int'(cfg_sym_count);
  endfunction

  function automatic int eff_seg();
    return (cfg_seg_count > SEG_DEPTH) ? SEG_DEPTH : int'(cfg_seg_count);
  endfunction

  // x - s never wraps because x >= s is checked first
  function automatic bit holds_addr(logic [63:0] x, logic [63:0] s, logic [63:0] l);
    return (x >= s) && ((x - s) < l);
  endfunction

  function automatic lookup_ans_t resolve_cmd(lookup_cmd_t c);
    lookup_ans_t r;
    logic [63:0] off;
    bit          seg_hit;
    r.found  = 1'b0;
    r.name   = NAME_NONE;
    r.offset = '0;
    case (c.func)
      FUNC_LOAD_SYM: begin
        tbl_sym_start[c.idx] = c.start;
        tbl_sym_len[c.idx]   = c.len[31:0];
        tbl_sym_name[c.idx]  = c.name;
      end
      FUNC_LOAD_SEG: begin
        if (c.idx < SEG_DEPTH) begin
          tbl_seg_base[c.idx] = c.start;
          tbl_seg_len[c.idx]  = c.len;
        end
      end
      FUNC_LOOKUP: begin
        off = c.pc;
        if (cfg_reloc) begin
          off = '0;
          seg_hit = 1'b0;
          for (int k = 0; k < eff_seg(); k++) begin
            if (!seg_hit && holds_addr(c.pc, tbl_seg_base[k], tbl_seg_len[k])) begin
              off = c.pc - tbl_seg_base[k];
              seg_hit = 1'b1;
            end
          end
        end
        r.offset = off;
        if (c.pc != '0) begin
          for (int j = 0; j < eff_sym(); j++) begin
            if (!r.found && holds_addr(off, tbl_sym_start[j], {32'h0, tbl_sym_len[j]})) begin
              r.found = 1'b1;
              r.name  = tbl_sym_name[j];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Driver: inputs move on the falling edge
  always @(negedge clk_i) begin : drv
    lookup_cmd_t c;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !cmd_taken) begin
      // transaction still waiting for busy_o to drop
    end else if (gap_left > 0) begin
      start_i <= 1'b0;
      gap_left = gap_left - 1;
    end else if (cmd_q.size() != 0 && !(cmd_q[0].drain_first && answer_q.size() != 0)) begin
      c = cmd_q.pop_front();
      func_i              <= c.func;
      entry_index_i       <= c.idx;
      entry_start_i       <= c.start;
      entry_length_i      <= c.len;
      entry_name_offset_i <= c.name;
      program_counter_i   <= c.pc;
      start_i             <= 1'b1;
      gap_left = pick_gap();
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: check the result first, then record what this edge accepted
  always @(posedge clk_i) begin : mon
    lookup_cmd_t c;
    lookup_ans_t want;
    if (!rst_ni) begin
      cmd_taken = 1'b0;
    end else begin
      if (done_o !== 1'b0) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result: found %b name %h offset %h", $time,
                   found_o, name_offset_o, module_offset_o);
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          if (found_o !== want.found) begin
            $display("%0t: found: expected %b, actual %b", $time, want.found, found_o);
            mismatches++;
          end
          if (name_offset_o !== want.name) begin
            $display("%0t: name_offset: expected %h, actual %h", $time, want.name,
                     name_offset_o);
            mismatches++;
          end
          if (module_offset_o !== want.offset) begin
            $display("%0t: module_offset: expected %h, actual %h", $time, want.offset,
                     module_offset_o);
            mismatches++;
          end
        end
      end
      cmd_taken = start_i && (busy_o === 1'b0);
      if (cmd_taken) begin
        c.func  = func_i;
        c.idx   = entry_index_i;
        c.start = entry_start_i;
        c.len   = entry_length_i;
        c.name  = entry_name_offset_i;
        c.pc    = program_counter_i;
        answer_q.push_back(resolve_cmd(c));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("address_range_symbol_lookup: mismatch");
      $finish;
    end
  end

  // APB write followed by a read-back of the same register
  task automatic write_reg(input arsl_reg_e r, input logic [31:0] v);
    logic [31:0] keep;
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {r, 2'b00};
    pwdata_i  <= v;
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (pready_o !== 1'b1) @(posedge clk_i);
    case (r)
      REG_SYMBOL_COUNT: begin
        cfg_sym_count = v[10:0];
        keep = {21'h0, v[10:0]};
      end
      REG_SEGMENT_COUNT: begin
        cfg_seg_count = v[3:0];
        keep = {28'h0, v[3:0]};
      end
      default: begin
        cfg_reloc = v[0];
        keep = {31'h0, v[0]};
      end
    endcase
    @(negedge clk_i);
    pwrite_i  <= 1'b0;
    penable_i <= 1'b0;
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (pready_o !== 1'b1) @(posedge clk_i);
    if (prdata_o !== keep) begin
      $display("%0t: register %s read-back: expected %h, actual %h", $time, r.name(),
               keep, prdata_o);
      mismatches++;
    end
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  task automatic set_config(input int syms, input int segs, input bit reloc);
    write_reg(REG_SYMBOL_COUNT, 32'(syms));
    write_reg(REG_SEGMENT_COUNT, 32'(segs));
    write_reg(REG_RELOCATE_ENABLE, 32'(reloc));
  endtask

  // Every transaction answers, so an empty answer queue with busy_o low means idle
  task automatic wait_idle();
    while (cmd_q.size() != 0 || start_i || answer_q.size() != 0 || busy_o !== 1'b0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic push_cmd(input logic [1:0] f, input logic [9:0] idx, input logic [63:0] s,
                          input logic [63:0] l, input logic [31:0] nm, input logic [63:0] pc);
    lookup_cmd_t c;
    c.func = f;
    c.idx = idx;
    c.start = s;
    c.len = l;
    c.name = nm;
    c.pc = pc;
    c.drain_first = drain_next || ($urandom_range(0, 29) == 0);
    drain_next = 1'b0;
    if (f == FUNC_LOAD_SYM) begin
      plan_sym_start[idx] = s;
      plan_sym_len[idx]   = l[31:0];
    end else if (f == FUNC_LOAD_SEG && idx < SEG_DEPTH) begin
      plan_seg_base[idx] = s;
      seg_planned[idx]   = 1'b1;
    end
    cmd_q.push_back(c);
  endtask

  task automatic load_sym(input logic [9:0] idx, input logic [63:0] s, input logic [63:0] l,
                          input logic [31:0] nm);
    push_cmd(FUNC_LOAD_SYM, idx, s, l, nm, rnd64());
  endtask

  task automatic load_seg(input logic [9:0] idx, input logic [63:0] b, input logic [63:0] l);
    push_cmd(FUNC_LOAD_SEG, idx, b, l, $urandom(), rnd64());
  endtask

  task automatic lookup(input logic [63:0] pc);
    push_cmd(FUNC_LOOKUP, 10'($urandom()), rnd64(), rnd64(), $urandom(), pc);
  endtask

  // Upper half is junk on purpose: the block keeps only 32 bits of a symbol length
  function automatic logic [63:0] pick_sym_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return {$urandom(), 32'($urandom_range(1, 256))};
    if (r < 93) return {$urandom(), 32'h0};
    return rnd64();
  endfunction

  function automatic logic [63:0] pick_seg_len();
    if ($urandom_range(0, 24) == 0) return '0;
    return 64'($urandom_range(4096, 12288));
  endfunction

  // Rewrite every searched slot so lookups of this phase land on known ranges
  task automatic lay_out_phase();
    for (int j = 0; j < eff_sym(); j++)
      load_sym(10'(j), phase_base + 64'($urandom_range(0, 4095)), pick_sym_len(), $urandom());
    for (int k = 0; k < eff_seg(); k++)
      if (cfg_reloc || !seg_planned[k]) load_seg(10'(k), rnd64() & ~64'hFFF, pick_seg_len());
  endtask

  task automatic lookup_near_symbol();
    int          n;
    int          m;
    int          j;
    logic [63:0] s;
    logic [63:0] off;
    logic [31:0] l;
    n = eff_sym();
    m = eff_seg();
    if (n == 0) begin
      lookup(rnd64());
      return;
    end
    j = $urandom_range(0, n - 1);
    s = plan_sym_start[j];
    l = plan_sym_len[j];
    case ($urandom_range(0, 5))
      0: off = s;
      1: off = s + l - 1;
      2: off = s + l;
      3: off = s - 1;
      default: off = s + ((l == 0) ? 64'h0 : 64'($urandom() % l));
    endcase
    if (cfg_reloc) off = (m > 0) ? plan_seg_base[$urandom_range(0, m - 1)] + off : rnd64();
    lookup(off);
  endtask

  task automatic mixed_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      lookup_near_symbol();
      mixed_items++;
    end else if (r < 63) begin
      case ($urandom_range(0, 3))
        0: lookup('0);
        1: lookup('1);
        default: lookup(rnd64());
      endcase
      mixed_items++;
    end else if (r < 76 && eff_sym() > 0) begin
      load_sym(10'($urandom_range(0, eff_sym() - 1)),
               phase_base + 64'($urandom_range(0, 4095)), pick_sym_len(), $urandom());
      mixed_items++;
    end else if (r < 84) begin
      load_sym(10'($urandom()), rnd64(), rnd64(), $urandom());
      mixed_items++;
    end else if (r < 94) begin
      if (cfg_reloc && eff_seg() > 0 && $urandom_range(0, 1) == 1) begin
        load_seg(10'($urandom_range(0, eff_seg() - 1)), rnd64() & ~64'hFFF, pick_seg_len());
        mixed_items++;
      end else begin
        load_seg(10'($urandom()), rnd64(), rnd64());
      end
    end else begin
      push_cmd(FUNC_UNUSED, 10'($urandom()), rnd64(), rnd64(), $urandom(), rnd64());
    end
  endtask

  initial begin
    int syms;
    int segs;
    bit reloc;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty tables, ignored loads, unused func
    lookup('0);
    lookup('1);
    push_cmd(FUNC_UNUSED, 10'h155, rnd64(), rnd64(), $urandom(), rnd64());
    load_seg(10'd8, rnd64(), rnd64());
    load_seg(10'h3FF, rnd64(), rnd64());
    load_sym(10'h3FF, rnd64(), rnd64(), $urandom());
    // seg0 and seg1 overlap; seg2 runs past the top of the address space
    load_seg(10'd0, 64'h0000_0000_4000_0000, 64'h1_0000);
    load_seg(10'd1, 64'h0000_0000_4000_8000, 64'h1_0000);
    load_seg(10'd2, 64'hFFFF_FFFF_FFFF_F000, 64'h2000);
    load_sym(10'd0, 64'h0, 64'h10, 32'h0000_0011);
    load_sym(10'd1, 64'h100, 64'hDEAD_0000_0000_0040, 32'h0000_0022);
    load_sym(10'd2, 64'h120, 64'h40, 32'h0000_0033);
    load_sym(10'd3, 64'hFFFF_FFFF_FFFF_FF00, 64'h1000, 32'hFFFF_FFFE);
    load_sym(10'd4, 64'h800, 64'h0, 32'h0000_0055);
    wait_idle();
    set_config(5, 3, 1'b0);
    lookup('0);
    lookup(64'h105);
    lookup(64'h130);
    lookup(64'h150);
    lookup('1);
    lookup(64'h800);
    wait_idle();
    write_reg(REG_RELOCATE_ENABLE, 1);
    lookup(64'h0000_0000_4000_0105);
    lookup(64'h0000_0000_4000_8105);
    lookup(64'hFFFF_FFFF_FFFF_F005);
    lookup(64'h10);
    lookup('0);
    wait_idle();

    drain_next = 1'b1;
    for (int p = 0; mixed_items < RANDOM_ITEMS; p++) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      case (p)
        0: set_config(5, 0, 1'b1);
        1: set_config(8, 15, 1'b1);
        2: set_config(0, 8, 1'b0);
        3: set_config(12, 8, 1'b1);
        5: begin
          // Full table: a count past the depth must search exactly all slots
          set_config(2047, eff_seg(), 1'b0);
          phase_base = rnd64();
          for (int j = 0; j < SYM_DEPTH; j++)
            load_sym(10'(j), phase_base + 64'(j) * 256, 64'($urandom_range(1, 200)),
                     $urandom());
          for (int k = 0; k < eff_seg(); k++)
            if (!seg_planned[k]) load_seg(10'(k), rnd64(), pick_seg_len());
          lookup(plan_sym_start[SYM_DEPTH - 1]);
          lookup(phase_base - 1);
          lookup_near_symbol();
          wait_idle();
          write_reg(REG_SYMBOL_COUNT, SYM_DEPTH);
          lookup(plan_sym_start[SYM_DEPTH - 1] + plan_sym_len[SYM_DEPTH - 1] - 1);
          lookup(phase_base - 1);
          wait_idle();
        end
        default: begin
          syms = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
          segs = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
          reloc = $urandom_range(0, 1);
          set_config(syms, segs, reloc);
        end
      endcase
      if (p != 5) begin
        phase_base = cfg_reloc ? 64'h0 : rnd64();
        lay_out_phase();
        repeat ($urandom_range(20, 40)) mixed_item();
        wait_idle();
      end
    end

    burst_mode = 1'b0;
    while (cmd_q.size() != 0 || start_i || answer_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("address_range_symbol_lookup: match");
    end else begin
      $display("address_range_symbol_lookup: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/arsl_pkg.sv
design/arsl_seg_table.sv
design/arsl_sym_table.sv
design/address_range_symbol_lookup.sv
design/arsl_checker.sv
tb/tb_address_range_symbol_lookup.sv
